// ===== hdl/set_containment_check_assert.svh =====
`ifndef SET_CONTAINMENT_CHECK_ASSERT_SVH
`define SET_CONTAINMENT_CHECK_ASSERT_SVH

// same-cycle implication on clk, quiet during reset
`define SCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk, quiet during reset
`define SCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/scc_pkg.sv =====
`default_nettype none

package scc_pkg;

  localparam int MAX_ITEMS = 16;
  localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int VAL_W     = 32;

  localparam logic [1:0] OP_PUSH_FIRST  = 2'd0;
  localparam logic [1:0] OP_PUSH_SECOND = 2'd1;
  localparam logic [1:0] OP_COMPARE     = 2'd2;

  localparam logic [1:0] REL_NONE            = 2'd0;
  localparam logic [1:0] REL_FIRST_IN_SECOND = 2'd1;
  localparam logic [1:0] REL_SECOND_IN_FIRST = 2'd2;
  localparam logic [1:0] REL_UNUSED          = 2'd3;

  // element of the second list travelling along the chain
  typedef struct packed {
    logic [VAL_W-1:0] data;
    logic             valid;
    logic             found;
  } b_token_t;

  typedef struct packed {
    logic a_we;
    logic b_we;
    logic load;
    logic scan;
    logic a_valid;
    logic b_valid;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/scc_if.sv =====
`default_nettype none

interface scc_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic signed [31:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

interface scc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] relation;
  logic       overflow;

  modport source (output valid, output relation, output overflow, input ready);
  modport sink (input valid, input relation, input overflow, output ready);
endinterface

`default_nettype wire

// ===== hdl/scc_cell.sv =====
`default_nettype none

module scc_cell (
  input  logic                       clk,
  input  scc_pkg::cell_ctrl_t        ctrl,
  input  logic [scc_pkg::VAL_W-1:0]  wdata,
  input  scc_pkg::b_token_t          b_in,
  output scc_pkg::b_token_t          b_out,
  output logic                       a_ok,
  output logic                       b_ok
);
  import scc_pkg::*;

  logic [VAL_W-1:0] a_data;
  logic             a_found;
  b_token_t         b_tok;
  logic             match;

  assign match = b_tok.valid && ctrl.a_valid && (a_data == b_tok.data);

  always_comb begin
    b_out       = b_tok;
    b_out.found = b_tok.found | match;
  end

  assign a_ok = !ctrl.a_valid || a_found;
  assign b_ok = !b_tok.valid || b_tok.found;

  always_ff @(posedge clk) begin
    if (ctrl.a_we) begin
      a_data <= wdata;
    end
    if (ctrl.b_we) begin
      b_tok.data <= wdata;
    end
    if (ctrl.load) begin
      b_tok.valid <= ctrl.b_valid;
      b_tok.found <= 1'b0;
      a_found     <= 1'b0;
    end else if (ctrl.scan) begin
      b_tok   <= b_in;
      a_found <= a_found | match;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/set_containment_check.sv =====
// push items: accepted back to back, no result
// compare item: the second list rotates once through the cell chain in the scan state,
// then the result is formed in the report state; input is stalled until the result enters the output register
// the next push may enter while a finished result waits in the output register
// synchronous active-high reset clears both counts, the overflow flag and the output valid;
// list contents are not cleared
`default_nettype none

`include "set_containment_check_assert.svh"

module set_containment_check (
  input logic      clk,
  input logic      rst,
  scc_in_if.sink   cmd,
  scc_out_if.source res
);
  import scc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_REPORT = 3'b100
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  first_count, second_count;
  logic              overflow_seen;
  logic [IDX_W-1:0]  scan_count;
  logic              out_valid;
  logic [1:0]        relation;
  logic              overflow;

  logic              cmd_accept, push_first, push_second, start_cmp;
  logic              first_full, second_full, res_free, finish;
  logic              all_a, all_b;

  cell_ctrl_t        ctrl [MAX_ITEMS];
  b_token_t          b_chain [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] a_ok, b_ok;

  assign cmd.ready   = (state == S_IDLE);
  assign cmd_accept  = cmd.valid && cmd.ready;
  assign push_first  = cmd_accept && (cmd.op == OP_PUSH_FIRST);
  assign push_second = cmd_accept && (cmd.op == OP_PUSH_SECOND);
  assign start_cmp   = cmd_accept && (cmd.op == OP_COMPARE);
  assign first_full  = (first_count == CNT_W'(MAX_ITEMS));
  assign second_full = (second_count == CNT_W'(MAX_ITEMS));
  assign res_free    = !out_valid || res.ready;
  assign finish      = (state == S_REPORT) && res_free;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    always_comb begin
      ctrl[i].a_we    = push_first && !first_full &&
                        (first_count[IDX_W-1:0] == IDX_W'(i));
      ctrl[i].b_we    = push_second && !second_full &&
                        (second_count[IDX_W-1:0] == IDX_W'(i));
      ctrl[i].load    = start_cmp;
      ctrl[i].scan    = (state == S_SCAN);
      ctrl[i].a_valid = (CNT_W'(i) < first_count);
      ctrl[i].b_valid = (CNT_W'(i) < second_count);
    end

    scc_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl[i]),
      .wdata (cmd.value),
      .b_in  (b_chain[(i + MAX_ITEMS - 1) % MAX_ITEMS]),
      .b_out (b_chain[i]),
      .a_ok  (a_ok[i]),
      .b_ok  (b_ok[i])
    );
  end

  assign all_a = &a_ok;
  assign all_b = &b_ok;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start_cmp) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_count == IDX_W'(MAX_ITEMS - 1)) begin
          state_next = S_REPORT;
        end
      end
      S_REPORT: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      scan_count    <= '0;
      first_count   <= '0;
      second_count  <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_SCAN) begin
        scan_count <= scan_count + IDX_W'(1);
      end else begin
        scan_count <= '0;
      end
      if (push_first) begin
        if (first_full) begin
          overflow_seen <= 1'b1;
        end else begin
          first_count <= first_count + CNT_W'(1);
        end
      end
      if (push_second) begin
        if (second_full) begin
          overflow_seen <= 1'b1;
        end else begin
          second_count <= second_count + CNT_W'(1);
        end
      end
      if (finish) begin
        first_count   <= '0;
        second_count  <= '0;
        overflow_seen <= 1'b0;
        out_valid     <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      overflow <= overflow_seen;
      if (all_a) begin
        relation <= REL_FIRST_IN_SECOND;
      end else if (all_b) begin
        relation <= REL_SECOND_IN_FIRST;
      end else begin
        relation <= REL_NONE;
      end
    end
  end

  assign res.valid    = out_valid;
  assign res.relation = relation;
  assign res.overflow = overflow;

  `SCC_ASSERT_NEXT(a_cmp_starts_scan, start_cmp, state == S_SCAN,
                   "compare item did not start a scan")
  `SCC_ASSERT_NEXT(a_finish_clears, finish,
                   first_count == '0 && second_count == '0 && !overflow_seen && out_valid,
                   "report did not clear the lists or raise the result")
  `SCC_ASSERT_NOW(a_count_bound, 1'b1,
                  first_count <= CNT_W'(MAX_ITEMS) && second_count <= CNT_W'(MAX_ITEMS),
                  "list count beyond capacity")
  `SCC_ASSERT_NOW(a_rel_code, out_valid, relation != REL_UNUSED,
                  "unused relation code on output")

endmodule

`default_nettype wire

// ===== tb/sv/scc_relation_checker.sv =====
`timescale 1ns / 1ps

module scc_relation_checker (
  input  logic clk,
  input  logic rst,
  scc_in_if    cmd,
  scc_out_if   res,
  output int   fail_count,
  output int   pending
);
  import scc_pkg::*;

  typedef struct packed {
    logic [1:0] relation;
    logic       overflow;
  } verdict_t;

  logic [VAL_W-1:0] first_set[$];
  logic [VAL_W-1:0] second_set[$];
  logic             dropped = 1'b0;
  verdict_t         verdict_queue[$];
  int               errors = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic log_mismatch(input string what, input int want, input int got);
    errors++;
    if (errors <= 10) begin
      $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // every element of one list occurs somewhere in the other
  function automatic bit all_members(input bit first_side);
    logic [VAL_W-1:0] src[$];
    logic [VAL_W-1:0] dst[$];
    bit               hit;
    if (first_side) begin
      src = first_set;
      dst = second_set;
    end else begin
      src = second_set;
      dst = first_set;
    end
    foreach (src[i]) begin
      hit = 1'b0;
      foreach (dst[j]) begin
        if (dst[j] == src[i]) hit = 1'b1;
      end
      if (!hit) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic verdict_t predict_verdict();
    verdict_t v;
    if (all_members(1'b1)) begin
      v.relation = REL_FIRST_IN_SECOND;
    end else if (all_members(1'b0)) begin
      v.relation = REL_SECOND_IN_FIRST;
    end else begin
      v.relation = REL_NONE;
    end
    v.overflow = dropped;
    return v;
  endfunction

  always @(posedge clk) begin : watch
    verdict_t want;
    if (rst) begin
      first_set.delete();
      second_set.delete();
      verdict_queue.delete();
      dropped = 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (verdict_queue.size() == 0) begin
          log_mismatch("relation with no result due", -1, int'(res.relation));
        end else begin
          want = verdict_queue.pop_front();
          if (res.relation !== want.relation) begin
            log_mismatch("relation", int'(want.relation), int'(res.relation));
          end
          if (res.overflow !== want.overflow) begin
            log_mismatch("overflow", int'(want.overflow), int'(res.overflow));
          end
        end
      end
      if (cmd.valid && cmd.ready) begin
        case (cmd.op)
          OP_PUSH_FIRST: begin
            if (first_set.size() < MAX_ITEMS) first_set.push_back(cmd.value);
            else dropped = 1'b1;
          end
          OP_PUSH_SECOND: begin
            if (second_set.size() < MAX_ITEMS) second_set.push_back(cmd.value);
            else dropped = 1'b1;
          end
          OP_COMPARE: begin
            verdict_queue.push_back(predict_verdict());
            first_set.delete();
            second_set.delete();
            dropped = 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
    fail_count <= errors;
    pending    <= verdict_queue.size();
  end

endmodule

// ===== tb/sv/tb_set_containment_check.sv =====
`timescale 1ns / 1ps

module tb_set_containment_check;
  import scc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int         ITEM_GOAL = 1450;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   items_sent = 0;
  int   burst_left = 0;
  int   rx_mode = 0;
  int   rx_left = 0;
  int   rx_phase = 0;

  scc_in_if  cmd_if ();
  scc_out_if res_if ();

  set_containment_check dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if)
  );

  scc_relation_checker relation_check (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_if),
    .res        (res_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3200000;
    $display("tb_set_containment_check: FAIL");
    $finish;
  end

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(32, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: res_if.ready <= 1'b1;
      1: res_if.ready <= ($urandom_range(0, 3) != 0);
      2: res_if.ready <= rx_phase[2] | rx_phase[4];
      default: res_if.ready <= ($urandom_range(0, 7) == 0);
    endcase
    rx_phase <= rx_phase + 1;
  end

  task automatic idle_for(input int n);
    repeat (n) begin
      @(negedge clk);
      cmd_if.valid <= 1'b0;
      cmd_if.op    <= 2'($urandom);
      cmd_if.value <= $urandom;
    end
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      idle_for(gap);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(0, 20);
    end
  endtask

  task automatic send_item(input logic [1:0] op, input logic [31:0] value);
    @(negedge clk);
    cmd_if.valid <= 1'b1;
    cmd_if.op    <= op;
    cmd_if.value <= value;
    do @(posedge clk); while (!cmd_if.ready);
    if (op != OP_UNUSED) items_sent++;
    pace();
  endtask

  task automatic drain_wait();
    @(negedge clk);
    cmd_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return $urandom_range(0, 6);
    if (r < 17) return $urandom_range(7, 16);
    return $urandom_range(15, 20);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4, 5: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  // two lists built to a chosen relation, pushed interleaved, then mostly compared
  task automatic run_scenario();
    logic [31:0] pool[8];
    logic [31:0] first_q[$];
    logic [31:0] second_q[$];
    int          n1;
    int          n2;
    int          shape;
    int          k;
    int          idx;
    n1 = pick_len();
    n2 = pick_len();
    shape = $urandom_range(0, 4);
    k = $urandom_range(1, 8);
    foreach (pool[i]) pool[i] = pick_value();
    case (shape)
      0, 3: begin
        repeat (n2) second_q.push_back(pool[$urandom_range(0, k - 1)]);
        repeat (n1) begin
          if (second_q.size() > 0) begin
            first_q.push_back(second_q[$urandom_range(0, second_q.size() - 1)]);
          end
        end
        // near miss: one element off by a single bit
        if (shape == 3 && first_q.size() > 0) begin
          idx = $urandom_range(0, first_q.size() - 1);
          first_q[idx] ^= 32'h1 << $urandom_range(0, 31);
        end
      end
      1: begin
        repeat (n1) first_q.push_back(pool[$urandom_range(0, k - 1)]);
        repeat (n2) begin
          if (first_q.size() > 0) begin
            second_q.push_back(first_q[$urandom_range(0, first_q.size() - 1)]);
          end
        end
      end
      2: begin
        repeat (n1) first_q.push_back(pool[$urandom_range(0, k - 1)]);
        repeat (n2) second_q.push_back(pool[$urandom_range(0, k - 1)]);
      end
      default: begin
        repeat (n1) first_q.push_back($urandom);
        repeat (n2) second_q.push_back($urandom);
      end
    endcase
    while (first_q.size() + second_q.size() > 0) begin
      if ($urandom_range(0, 19) == 0) send_item(OP_UNUSED, $urandom);
      if (second_q.size() == 0 || (first_q.size() > 0 && $urandom_range(0, 1) == 1)) begin
        send_item(OP_PUSH_FIRST, first_q.pop_front());
      end else begin
        send_item(OP_PUSH_SECOND, second_q.pop_front());
      end
    end
    if ($urandom_range(0, 9) != 0) send_item(OP_COMPARE, $urandom);
    if ($urandom_range(0, 14) == 0) send_item(OP_COMPARE, $urandom);
  endtask

  initial begin
    rst          = 1'b1;
    cmd_if.valid = 1'b0;
    cmd_if.op    = OP_PUSH_FIRST;
    cmd_if.value = '0;
    res_if.ready = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // both lists empty
    send_item(OP_COMPARE, 32'h0);
    // extremes, neither contains the other
    send_item(OP_PUSH_FIRST, 32'h8000_0000);
    send_item(OP_PUSH_SECOND, 32'h7fff_ffff);
    send_item(OP_COMPARE, 32'hffff_ffff);
    // empty first list
    send_item(OP_PUSH_SECOND, 32'hffff_ffff);
    send_item(OP_COMPARE, 32'h0);
    // empty second list
    send_item(OP_PUSH_FIRST, 32'h0);
    send_item(OP_COMPARE, 32'h0);
    // unused op and duplicates
    send_item(OP_UNUSED, 32'h5555_aaaa);
    send_item(OP_PUSH_FIRST, 32'd5);
    send_item(OP_PUSH_SECOND, 32'd5);
    send_item(OP_PUSH_SECOND, 32'd5);
    send_item(OP_COMPARE, 32'h0);
    // differ only in the sign bit
    send_item(OP_PUSH_FIRST, 32'h0000_0001);
    send_item(OP_PUSH_SECOND, 32'h8000_0001);
    send_item(OP_COMPARE, 32'h0);
    drain_wait();

    while (items_sent < ITEM_GOAL) begin
      run_scenario();
      if ($urandom_range(0, 14) == 0) drain_wait();
    end

    drain_wait();
    repeat (4 * MAX_ITEMS) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_set_containment_check: PASS");
    end else begin
      $display("tb_set_containment_check: FAIL");
    end
    $finish;
  end

endmodule

// ===== set_containment_check.f =====
+incdir+hdl
hdl/scc_pkg.sv
hdl/scc_if.sv
hdl/scc_cell.sv
hdl/set_containment_check.sv
tb/sv/scc_relation_checker.sv
tb/sv/tb_set_containment_check.sv
